// ===== hw/rtl/ppg_pkg.sv =====
// shared types, constants and lookup functions for the power profile governor
`default_nettype none

package ppg_pkg;

    localparam int unsigned WINDOW_W   = 31;
    localparam int unsigned LOAD_W     = 16;
    localparam int unsigned AC_W       = 2;
    localparam int unsigned PROFILE_W  = 2;
    localparam int unsigned EPP_W      = 8;
    localparam int unsigned PACK_W     = 2;
    localparam int unsigned COALESCE_W = 6;
    localparam int unsigned POLL_W     = 13;
    localparam int unsigned COUNT_W    = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 31;
    localparam int unsigned LEFT_W     = WINDOW_W + 2;

    localparam logic [COUNT_W-1:0] DOWNSHIFT_POLLS = COUNT_W'(3);

    localparam logic [PROFILE_W-1:0] PROFILE_PERF      = 2'd0;
    localparam logic [PROFILE_W-1:0] PROFILE_BALANCED  = 2'd1;
    localparam logic [PROFILE_W-1:0] PROFILE_POWERSAVE = 2'd2;
    localparam logic [PROFILE_W-1:0] PROFILE_NONE      = 2'd3;

    localparam logic [AC_W-1:0] AC_BATTERY = 2'd0;

    localparam logic [CFG_IDX_W-1:0] REG_INTERACTIVE_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOAD_HIGH          = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOAD_LOW           = 2'd2;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET    = WINDOW_W'(10000);
    localparam logic [LOAD_W-1:0]   LOAD_HIGH_RESET = LOAD_W'(384);
    localparam logic [LOAD_W-1:0]   LOAD_LOW_RESET  = LOAD_W'(256);

    localparam logic [POLL_W-1:0] POLL_ACTIVE = POLL_W'(250);
    localparam logic [POLL_W-1:0] POLL_IDLE   = POLL_W'(500);
    localparam logic [POLL_W-1:0] POLL_SLOW   = POLL_W'(5000);
    localparam logic [LEFT_W-1:0] WINDOW_SLACK = LEFT_W'(100);

    typedef struct packed {
        logic [WINDOW_W-1:0] interactive_window_ms;
        logic [LOAD_W-1:0]   load_high_q8;
        logic [LOAD_W-1:0]   load_low_q8;
    } cfg_t;

    typedef struct packed {
        logic                 load_latch;
        logic [PROFILE_W-1:0] current_profile;
        logic [COUNT_W-1:0]   downshift_count;
    } gov_state_t;

    typedef struct packed {
        logic [AC_W-1:0]     ac_state;
        logic [LOAD_W-1:0]   load_q8;
        logic [WINDOW_W-1:0] idle_ms;
        logic                compositor_active;
    } sample_t;

    typedef struct packed {
        logic [PROFILE_W-1:0]  profile;
        logic [EPP_W-1:0]      epp_value;
        logic [PACK_W-1:0]     pack_mode;
        logic [COALESCE_W-1:0] coalesce_time;
        logic                  applied;
        logic [POLL_W-1:0]     next_poll_ms;
    } result_t;

    function automatic logic [EPP_W-1:0] profile_epp(input logic [PROFILE_W-1:0] p);
        logic [EPP_W-1:0] v;
        case (p)
            PROFILE_BALANCED:  v = EPP_W'(128);
            PROFILE_POWERSAVE: v = EPP_W'(240);
            default:           v = EPP_W'(32);
        endcase
        return v;
    endfunction

    function automatic logic [PACK_W-1:0] profile_pack(input logic [PROFILE_W-1:0] p);
        logic [PACK_W-1:0] v;
        case (p)
            PROFILE_BALANCED:  v = PACK_W'(1);
            PROFILE_POWERSAVE: v = PACK_W'(2);
            default:           v = PACK_W'(0);
        endcase
        return v;
    endfunction

    function automatic logic [COALESCE_W-1:0] profile_coalesce(
        input logic [PROFILE_W-1:0] p
    );
        logic [COALESCE_W-1:0] v;
        case (p)
            PROFILE_BALANCED:  v = COALESCE_W'(20);
            PROFILE_POWERSAVE: v = COALESCE_W'(50);
            default:           v = COALESCE_W'(0);
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ppg_if.sv =====
// handshake channel interfaces for samples, results and register writes
`default_nettype none

interface ppg_sample_if;
    import ppg_pkg::*;
    logic                valid;
    logic                ready;
    logic [AC_W-1:0]     ac_state;
    logic [LOAD_W-1:0]   load_q8;
    logic [WINDOW_W-1:0] idle_ms;
    logic                compositor_active;

    modport source (output valid, ac_state, load_q8, idle_ms, compositor_active,
                    input ready);
    modport sink (input valid, ac_state, load_q8, idle_ms, compositor_active,
                  output ready);
endinterface

interface ppg_result_if;
    import ppg_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [PROFILE_W-1:0]  profile;
    logic [EPP_W-1:0]      epp_value;
    logic [PACK_W-1:0]     pack_mode;
    logic [COALESCE_W-1:0] coalesce_time;
    logic                  applied;
    logic [POLL_W-1:0]     next_poll_ms;

    modport source (output valid, profile, epp_value, pack_mode, coalesce_time,
                    applied, next_poll_ms, input ready);
    modport sink (input valid, profile, epp_value, pack_mode, coalesce_time,
                  applied, next_poll_ms, output ready);
endinterface

interface ppg_cfg_if;
    import ppg_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/power_profile_governor.sv =====
// top level: picks a power profile from each poll sample
// the result beat for an accepted sample is held in the output register
// throughput: one sample per cycle while the result side is ready; the single output register refills as it drains
// the whole decision is one combinational pass between the state and output registers
// reset: config and state registers return to their defaults, no latch, no profile, no pending downshift
// register writes are taken every cycle with no stall
`default_nettype none

module power_profile_governor (
    input  wire logic     clk,
    input  wire logic     rst_n,
    ppg_sample_if.sink    sample,
    ppg_result_if.source  result,
    ppg_cfg_if.sink       cfg
);
    import ppg_pkg::*;

    cfg_t       cfg_reg;
    gov_state_t state_reg;
    gov_state_t state_next;
    sample_t    sample_beat;
    result_t    result_next;
    result_t    result_reg;
    logic       out_valid_reg;
    logic       take;

    assign sample.ready = !out_valid_reg || result.ready;
    assign take         = sample.valid && sample.ready;
    assign cfg.ready    = 1'b1;

    assign sample_beat.ac_state          = sample.ac_state;
    assign sample_beat.load_q8           = sample.load_q8;
    assign sample_beat.idle_ms           = sample.idle_ms;
    assign sample_beat.compositor_active = sample.compositor_active;

    ppg_decide u_decide (
        .cfg_regs   (cfg_reg),
        .state      (state_reg),
        .sample     (sample_beat),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.interactive_window_ms <= WINDOW_RESET;
            cfg_reg.load_high_q8          <= LOAD_HIGH_RESET;
            cfg_reg.load_low_q8           <= LOAD_LOW_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_INTERACTIVE_WINDOW: cfg_reg.interactive_window_ms <= cfg.data;
                REG_LOAD_HIGH:          cfg_reg.load_high_q8 <= cfg.data[LOAD_W-1:0];
                REG_LOAD_LOW:           cfg_reg.load_low_q8 <= cfg.data[LOAD_W-1:0];
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.load_latch      <= 1'b0;
            state_reg.current_profile <= PROFILE_NONE;
            state_reg.downshift_count <= '0;
            out_valid_reg             <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.profile       = result_reg.profile;
    assign result.epp_value     = result_reg.epp_value;
    assign result.pack_mode     = result_reg.pack_mode;
    assign result.coalesce_time = result_reg.coalesce_time;
    assign result.applied       = result_reg.applied;
    assign result.next_poll_ms  = result_reg.next_poll_ms;

`ifndef SYNTHESIS
    a_count_below_polls: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.downshift_count < DOWNSHIFT_POLLS)
        else $error("downshift count reached its limit");

    a_pending_not_powersave: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.downshift_count != '0) |-> (state_reg.current_profile != PROFILE_POWERSAVE)
        && (state_reg.current_profile != PROFILE_NONE))
        else $error("downshift pending with no lower profile to go to");

    a_ac_forces_perf: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (sample.ac_state != AC_BATTERY)) |=>
        (result.valid && (result.profile == PROFILE_PERF)))
        else $error("sample on external power did not give perf");

    a_result_has_profile: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.profile != PROFILE_NONE))
        else $error("result beat without a profile");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/ppg_decide.sv =====
// per-sample profile decision: next governor state and the result beat
`default_nettype none

module ppg_decide (
    input  wire ppg_pkg::cfg_t       cfg_regs,
    input  wire ppg_pkg::gov_state_t state,
    input  wire ppg_pkg::sample_t    sample,
    output ppg_pkg::gov_state_t      state_next,
    output ppg_pkg::result_t         result
);
    import ppg_pkg::*;

    logic                 latch_next;
    logic [PROFILE_W-1:0] want;
    logic [PROFILE_W-1:0] profile_next;
    logic [COUNT_W-1:0]   count_next;
    logic [COUNT_W-1:0]   count_inc;
    logic                 applied;
    logic                 interactive;
    logic [LEFT_W-1:0]    left;
    logic [POLL_W-1:0]    poll;

    assign interactive = sample.idle_ms < cfg_regs.interactive_window_ms;
    assign count_inc   = state.downshift_count + COUNT_W'(1);

    // wanted profile with the battery load latch
    always_comb
    begin
        latch_next = state.load_latch;
        if (sample.ac_state != AC_BATTERY)
        begin
            want = PROFILE_PERF;
        end
        else if (state.load_latch && !(sample.load_q8 < cfg_regs.load_low_q8))
        begin
            want = PROFILE_PERF;
        end
        else if (!state.load_latch && (sample.load_q8 > cfg_regs.load_high_q8))
        begin
            latch_next = 1'b1;
            want       = PROFILE_PERF;
        end
        else
        begin
            latch_next = 1'b0;
            want       = interactive ? PROFILE_BALANCED : PROFILE_POWERSAVE;
        end
    end

    // upshift at once, downshift after a run of samples
    always_comb
    begin
        profile_next = state.current_profile;
        count_next   = '0;
        applied      = 1'b0;
        if ((state.current_profile == PROFILE_NONE) || (want < state.current_profile))
        begin
            profile_next = want;
            applied      = 1'b1;
        end
        else if (want > state.current_profile)
        begin
            if (count_inc >= DOWNSHIFT_POLLS)
            begin
                profile_next = want;
                applied      = 1'b1;
            end
            else
            begin
                count_next = count_inc;
            end
        end
    end

    assign left = {2'b00, cfg_regs.interactive_window_ms} - {2'b00, sample.idle_ms}
                  + WINDOW_SLACK;

    always_comb
    begin
        if (!sample.compositor_active)
        begin
            poll = (profile_next == PROFILE_POWERSAVE) ? POLL_IDLE : POLL_ACTIVE;
        end
        else if (count_next != '0)
        begin
            poll = POLL_IDLE;
        end
        else if (profile_next == PROFILE_BALANCED)
        begin
            if (left[LEFT_W-1] || (left < LEFT_W'(POLL_ACTIVE)))
            begin
                poll = POLL_ACTIVE;
            end
            else if (left > LEFT_W'(POLL_SLOW))
            begin
                poll = POLL_SLOW;
            end
            else
            begin
                poll = left[POLL_W-1:0];
            end
        end
        else
        begin
            poll = POLL_SLOW;
        end
    end

    assign state_next.load_latch      = latch_next;
    assign state_next.current_profile = profile_next;
    assign state_next.downshift_count = count_next;

    assign result.profile       = profile_next;
    assign result.epp_value     = profile_epp(profile_next);
    assign result.pack_mode     = profile_pack(profile_next);
    assign result.coalesce_time = profile_coalesce(profile_next);
    assign result.applied       = applied;
    assign result.next_poll_ms  = poll;

endmodule

`default_nettype wire

// ===== test/tb_power_profile_governor.sv =====
// self-checking testbench for power_profile_governor: directed and random samples against a predictor
module tb_power_profile_governor;
    timeunit 1ns;
    timeprecision 1ps;

    import ppg_pkg::*;

    localparam logic [AC_W-1:0]      AC_MAINS     = 2'd1;
    localparam logic [AC_W-1:0]      AC_UNKNOWN   = 2'd2;
    localparam logic [AC_W-1:0]      AC_UNDEFINED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 2'd3;
    localparam logic [WINDOW_W-1:0]  IDLE_MAX     = '1;
    localparam logic [LOAD_W-1:0]    LOAD_MAX     = '1;

    class profile_scoreboard;
        logic [WINDOW_W-1:0]  window_ms;
        logic [LOAD_W-1:0]    high_q8;
        logic [LOAD_W-1:0]    low_q8;
        logic                 latch_on;
        logic [PROFILE_W-1:0] active_profile;
        logic [COUNT_W-1:0]   pending_downs;
        result_t              expected_results[$];
        int unsigned          errors;

        function new();
            window_ms      = WINDOW_RESET;
            high_q8        = LOAD_HIGH_RESET;
            low_q8         = LOAD_LOW_RESET;
            latch_on       = 1'b0;
            active_profile = PROFILE_NONE;
            pending_downs  = '0;
            errors         = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_INTERACTIVE_WINDOW: window_ms = value[WINDOW_W-1:0];
                REG_LOAD_HIGH:          high_q8   = value[LOAD_W-1:0];
                REG_LOAD_LOW:           low_q8    = value[LOAD_W-1:0];
                default:                ;
            endcase
        endfunction

        function void note_sample(sample_t s);
            logic [PROFILE_W-1:0] want;
            logic [PROFILE_W-1:0] shown;
            logic                 decided;
            longint               left;
            result_t              r;

            // wanted profile, with the battery load latch
            decided = 1'b0;
            want    = PROFILE_PERF;
            if (s.ac_state != AC_BATTERY)
                decided = 1'b1;
            else if (latch_on)
            begin
                if (s.load_q8 < low_q8)
                    latch_on = 1'b0;
                else
                    decided = 1'b1;
            end
            else if (s.load_q8 > high_q8)
            begin
                latch_on = 1'b1;
                decided  = 1'b1;
            end
            if (!decided)
                want = (s.idle_ms < window_ms) ? PROFILE_BALANCED : PROFILE_POWERSAVE;

            r.applied = 1'b0;
            if (active_profile == PROFILE_NONE || want < active_profile)
            begin
                active_profile = want;
                pending_downs  = '0;
                r.applied      = 1'b1;
            end
            else if (want > active_profile)
            begin
                pending_downs = pending_downs + 1'b1;
                if (pending_downs >= DOWNSHIFT_POLLS)
                begin
                    active_profile = want;
                    pending_downs  = '0;
                    r.applied      = 1'b1;
                end
            end
            else
                pending_downs = '0;

            shown     = (active_profile == PROFILE_NONE) ? PROFILE_PERF : active_profile;
            r.profile = shown;
            case (shown)
                PROFILE_BALANCED:
                begin
                    r.epp_value     = 8'd128;
                    r.pack_mode     = 2'd1;
                    r.coalesce_time = 6'd20;
                end
                PROFILE_POWERSAVE:
                begin
                    r.epp_value     = 8'd240;
                    r.pack_mode     = 2'd2;
                    r.coalesce_time = 6'd50;
                end
                default:
                begin
                    r.epp_value     = 8'd32;
                    r.pack_mode     = 2'd0;
                    r.coalesce_time = 6'd0;
                end
            endcase

            if (!s.compositor_active)
                r.next_poll_ms = (active_profile == PROFILE_POWERSAVE) ? POLL_IDLE : POLL_ACTIVE;
            else if (pending_downs != '0)
                r.next_poll_ms = POLL_IDLE;
            else if (active_profile == PROFILE_BALANCED)
            begin
                // time left in the interactive window, clamped
                left = longint'(window_ms) - longint'(s.idle_ms) + 100;
                if (left < longint'(POLL_ACTIVE))
                    left = longint'(POLL_ACTIVE);
                if (left > longint'(POLL_SLOW))
                    left = longint'(POLL_SLOW);
                r.next_poll_ms = POLL_W'(left);
            end
            else
                r.next_poll_ms = POLL_SLOW;

            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0)
            begin
                $error("result beat with no sample pending: profile %0d", got.profile);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("profile", want.profile, got.profile);
            compare_field("epp_value", want.epp_value, got.epp_value);
            compare_field("pack_mode", want.pack_mode, got.pack_mode);
            compare_field("coalesce_time", want.coalesce_time, got.coalesce_time);
            compare_field("applied", want.applied, got.applied);
            compare_field("next_poll_ms", want.next_poll_ms, got.next_poll_ms);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   long_hold;
    bit   tx_gaps;
    int   rx_mode;

    profile_scoreboard sb;

    ppg_sample_if smp_ch ();
    ppg_result_if res_ch ();
    ppg_cfg_if    cfg_ch ();

    power_profile_governor dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (smp_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("power_profile_governor regression: fail");
        $finish;
    end

    always @(posedge clk)
    begin : beat_monitor
        result_t got;
        sample_t acc;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                got.profile       = res_ch.profile;
                got.epp_value     = res_ch.epp_value;
                got.pack_mode     = res_ch.pack_mode;
                got.coalesce_time = res_ch.coalesce_time;
                got.applied       = res_ch.applied;
                got.next_poll_ms  = res_ch.next_poll_ms;
                sb.check_result(got);
            end
            if (smp_ch.valid && smp_ch.ready)
            begin
                acc.ac_state          = smp_ch.ac_state;
                acc.load_q8           = smp_ch.load_q8;
                acc.idle_ms           = smp_ch.idle_ms;
                acc.compositor_active = smp_ch.compositor_active;
                sb.note_sample(acc);
            end
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_reg(cfg_ch.index, cfg_ch.data);
        end
    end

    // result side stall patterns
    initial
    begin : result_sink
        int stall_left;
        stall_left   = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                res_ch.ready = 1'b0;
                repeat (60) @(negedge clk);
                long_hold = 1'b0;
            end
            else
                case (rx_mode)
                    0: res_ch.ready = 1'b1;
                    1: res_ch.ready = 1'($urandom_range(0, 1));
                    2: res_ch.ready = ($urandom_range(0, 9) != 0);
                    default:
                    begin
                        if (stall_left > 0)
                        begin
                            res_ch.ready = 1'b0;
                            stall_left--;
                        end
                        else
                        begin
                            res_ch.ready = 1'b1;
                            if ($urandom_range(0, 7) == 0)
                                stall_left = $urandom_range(1, 8);
                        end
                    end
                endcase
        end
    end

    function automatic sample_t mk(logic [AC_W-1:0] ac, logic [LOAD_W-1:0] load,
                                   logic [WINDOW_W-1:0] idle, logic comp);
        sample_t s;
        s.ac_state          = ac;
        s.load_q8           = load;
        s.idle_ms           = idle;
        s.compositor_active = comp;
        return s;
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        longint  v;
        s.ac_state = ($urandom_range(0, 9) < 7) ? AC_BATTERY : AC_W'($urandom_range(1, 3));
        case ($urandom_range(0, 4))
            0: s.load_q8 = '0;
            1: s.load_q8 = LOAD_MAX;
            2: s.load_q8 = sb.high_q8 + LOAD_W'($urandom_range(0, 4)) - LOAD_W'(2);
            3: s.load_q8 = sb.low_q8 + LOAD_W'($urandom_range(0, 4)) - LOAD_W'(2);
            default: s.load_q8 = LOAD_W'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0: v = 0;
            1: v = longint'(IDLE_MAX);
            2: v = longint'(sb.window_ms) + longint'($urandom_range(0, 6)) - 3;
            3: v = longint'(WINDOW_W'($urandom));
            4: v = longint'($urandom_range(0, 20000));
            default: v = longint'(sb.window_ms) - longint'($urandom_range(0, 5300));
        endcase
        if (v < 0)
            v = 0;
        if (v > longint'(IDLE_MAX))
            v = longint'(IDLE_MAX);
        s.idle_ms           = WINDOW_W'(v);
        s.compositor_active = 1'($urandom_range(0, 1));
        return s;
    endfunction

    task automatic send_sample(sample_t s);
        smp_ch.valid             = 1'b1;
        smp_ch.ac_state          = s.ac_state;
        smp_ch.load_q8           = s.load_q8;
        smp_ch.idle_ms           = s.idle_ms;
        smp_ch.compositor_active = s.compositor_active;
        do
            @(posedge clk);
        while (!smp_ch.ready);
        @(negedge clk);
    endtask

    task automatic pause_input(int cycles);
        smp_ch.valid = 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic drain_results();
        smp_ch.valid = 1'b0;
        while (sb.expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // runs of repeated samples so that downshifts complete
    task automatic send_random(int count);
        sample_t run_item;
        int      run_left;
        int      burst;
        run_left = 0;
        while (count > 0)
        begin
            burst = $urandom_range(1, 30);
            while (burst > 0 && count > 0)
            begin
                if (run_left == 0)
                begin
                    run_item = random_sample();
                    run_left = $urandom_range(1, 5);
                end
                run_item.compositor_active = 1'($urandom_range(0, 1));
                send_sample(run_item);
                run_left--;
                burst--;
                count--;
            end
            if (tx_gaps)
                pause_input($urandom_range(0, 6));
        end
    endtask

    initial
    begin : stimulus
        logic [LOAD_W-1:0] hi;
        sb                       = new();
        rst_n                    = 1'b0;
        long_hold                = 1'b0;
        tx_gaps                  = 1'b1;
        rx_mode                  = 1;
        smp_ch.valid             = 1'b0;
        smp_ch.ac_state          = '0;
        smp_ch.load_q8           = '0;
        smp_ch.idle_ms           = '0;
        smp_ch.compositor_active = 1'b0;
        cfg_ch.valid             = 1'b0;
        cfg_ch.index             = '0;
        cfg_ch.data              = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // first sample, poll window clamps, interrupted and completed downshift
        send_sample(mk(AC_BATTERY, '0, '0, 1'b0));
        send_sample(mk(AC_BATTERY, '0, '0, 1'b1));
        send_sample(mk(AC_BATTERY, '0, 31'd9900, 1'b1));
        send_sample(mk(AC_BATTERY, '0, 31'd8000, 1'b1));
        send_sample(mk(AC_BATTERY, '0, IDLE_MAX, 1'b1));
        send_sample(mk(AC_BATTERY, '0, '0, 1'b1));
        send_sample(mk(AC_BATTERY, '0, IDLE_MAX, 1'b0));
        send_sample(mk(AC_BATTERY, '0, IDLE_MAX, 1'b1));
        send_sample(mk(AC_BATTERY, '0, IDLE_MAX, 1'b0));
        // ac present, unknown and the undefined code
        send_sample(mk(AC_MAINS, '0, IDLE_MAX, 1'b1));
        send_sample(mk(AC_UNKNOWN, LOAD_MAX, '0, 1'b0));
        send_sample(mk(AC_UNDEFINED, '0, '0, 1'b1));
        // latch thresholds, equal loads, latch held across ac
        send_sample(mk(AC_BATTERY, 16'd384, '0, 1'b1));
        send_sample(mk(AC_BATTERY, 16'd385, '0, 1'b1));
        send_sample(mk(AC_BATTERY, 16'd256, '0, 1'b0));
        send_sample(mk(AC_MAINS, '0, '0, 1'b1));
        send_sample(mk(AC_BATTERY, 16'd300, '0, 1'b1));
        send_sample(mk(AC_BATTERY, 16'd255, '0, 1'b1));
        send_sample(mk(AC_BATTERY, LOAD_MAX, '0, 1'b0));
        send_sample(mk(AC_BATTERY, '0, '0, 1'b1));
        send_sample(mk(AC_BATTERY, '0, '0, 1'b1));
        send_sample(mk(AC_BATTERY, '0, '0, 1'b1));
        // idle equal to the window is not interactive
        send_sample(mk(AC_BATTERY, '0, 31'd10000, 1'b1));
        send_sample(mk(AC_BATTERY, '0, 31'd9999, 1'b1));

        for (int phase = 0; phase < 8; phase++)
        begin
            drain_results();
            case (phase)
                1:
                begin
                    write_cfg(REG_INTERACTIVE_WINDOW, '0);
                    write_cfg(REG_LOAD_HIGH, '0);
                    write_cfg(REG_LOAD_LOW, '0);
                end
                2:
                begin
                    write_cfg(REG_INTERACTIVE_WINDOW, IDLE_MAX);
                    write_cfg(REG_LOAD_HIGH, CFG_DATA_W'(LOAD_MAX));
                    write_cfg(REG_LOAD_LOW, CFG_DATA_W'(LOAD_MAX));
                end
                3:
                begin
                    write_cfg(REG_INTERACTIVE_WINDOW, CFG_DATA_W'($urandom));
                    write_cfg(REG_LOAD_HIGH, CFG_DATA_W'(LOAD_W'($urandom)));
                    write_cfg(REG_LOAD_LOW, CFG_DATA_W'(LOAD_W'($urandom)));
                end
                4:
                begin
                    hi = LOAD_W'($urandom_range(256, 65535));
                    write_cfg(REG_INTERACTIVE_WINDOW, CFG_DATA_W'($urandom_range(0, 20000)));
                    write_cfg(REG_LOAD_HIGH, CFG_DATA_W'(hi));
                    write_cfg(REG_LOAD_LOW, CFG_DATA_W'($urandom_range(0, hi)));
                end
                5:
                begin
                    write_cfg(REG_INTERACTIVE_WINDOW, IDLE_MAX);
                    write_cfg(REG_LOAD_HIGH, '0);
                    write_cfg(REG_LOAD_LOW, CFG_DATA_W'(LOAD_MAX));
                end
                6:
                begin
                    write_cfg(REG_INTERACTIVE_WINDOW, CFG_DATA_W'($urandom_range(0, 12000)));
                    write_cfg(REG_LOAD_HIGH, CFG_DATA_W'($urandom_range(0, 1024)));
                    write_cfg(REG_LOAD_LOW, CFG_DATA_W'($urandom_range(0, 1024)));
                    write_cfg(REG_UNUSED, CFG_DATA_W'($urandom));
                end
                7:
                begin
                    write_cfg(REG_INTERACTIVE_WINDOW, WINDOW_RESET);
                    write_cfg(REG_LOAD_HIGH, CFG_DATA_W'(LOAD_HIGH_RESET));
                    write_cfg(REG_LOAD_LOW, CFG_DATA_W'(LOAD_LOW_RESET));
                end
                default: ;
            endcase
            rx_mode = phase % 4;
            tx_gaps = !(phase == 1 || phase == 4);
            if (phase == 2)
            begin
                // receiver holds off while samples keep coming
                long_hold = 1'b1;
                for (int i = 0; i < 30; i++)
                    send_sample(random_sample());
                send_random(220);
            end
            else if (phase == 4)
            begin
                send_random(120);
                drain_results();
                send_random(130);
            end
            else
                send_random(250);
        end

        drain_results();
        repeat (5) @(negedge clk);
        if (sb.errors == 0)
            $display("power_profile_governor regression: pass");
        else
            $display("power_profile_governor regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ppg_pkg.sv
hw/rtl/ppg_if.sv
hw/rtl/ppg_decide.sv
hw/rtl/power_profile_governor.sv
test/tb_power_profile_governor.sv
